// ----- sv/gdda_pkg.sv -----
// ----------------------------------------------------------------------------
// gdda_pkg
// Shared types and constants of the grid ray caster: map geometry, fixed
// point scales, command and selection codes, controller/datapath bundles.
// ----------------------------------------------------------------------------
package gdda_pkg;

   localparam int MAP_SIDE   = 16;
   localparam int CELL_BITS  = 4;
   localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_BITS  = 2 * CELL_BITS;
   localparam int FRAC_BITS  = 12;
   localparam int CELL_ONE   = 1 << FRAC_BITS;
   localparam int DIR_FRAC   = 14;
   localparam int TEX_WIDTH  = 32;
   localparam int TEX_BITS   = 5;
   localparam int TEX_SHIFT  = FRAC_BITS - TEX_BITS;
   localparam int DIST_BITS  = 18;
   localparam int DIST_MAX   = (1 << DIST_BITS) - 1;
   localparam int MAX_DEPTH_RESET = 65536;

   // shared divider geometry
   localparam int DIV_N     = 33;
   localparam int DIV_D     = 23;
   localparam int DIV_CNT_W = 6;

   // item commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // multiplier operand selection
   localparam logic [1:0] MUL_NX_AY = 2'd0;
   localparam logic [1:0] MUL_NY_AX = 2'd1;
   localparam logic [1:0] MUL_P_A   = 2'd2;
   localparam logic [1:0] MUL_N_D   = 2'd3;

   // divider use
   localparam logic DIV_DIST = 1'b0;
   localparam logic DIV_TEX  = 1'b1;

   // csr register indexes
   localparam logic CSR_MAX_DEPTH = 1'b0;

   typedef struct packed {
      logic       accept;
      logic       mul_x;
      logic       mul_y;
      logic       step;
      logic       set_esc;
      logic       latch_wt;
      logic       latch_wpart;
      logic       latch_w;
      logic       div_start;
      logic       div_sel;
      logic       latch_dist;
      logic       latch_tex;
      logic       load_out;
      logic [1:0] mul_sel;
   } dda_cmd_type;

   typedef struct packed {
      logic zero_dir;
      logic step_out;
      logic cell_hit;
      logic div_busy;
      logic rsp_free;
   } dda_status_type;

endpackage

// ----- sv/gdda_ram.sv -----
// ----------------------------------------------------------------------------
// gdda_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gdda_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/gdda_div.sv -----
// ----------------------------------------------------------------------------
// gdda_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// distance and texture column quotients.
// ----------------------------------------------------------------------------
module gdda_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gdda_pkg::DIV_N-1:0] dividend,
   input  logic [gdda_pkg::DIV_D-1:0] divisor,
   output logic                      busy,
   output logic [gdda_pkg::DIV_N-1:0] quotient,
   output logic                      rem_nz
);
   import gdda_pkg::*;

   logic [DIV_D-1:0]     rem_ff, rem_in;
   logic [DIV_N-1:0]     quo_ff, quo_in;
   logic [DIV_D-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DIV_D:0]       trial;
   logic [DIV_D:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_N-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
         quo_in = {quo_ff[DIV_N-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
   assign rem_nz   = |rem_ff;

endmodule

// ----- sv/gdda_datapath.sv -----
// ----------------------------------------------------------------------------
// gdda_datapath
// Wall map, ray stepping registers, shared multiplier and divider, result
// register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module gdda_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  gdda_pkg::dda_cmd_type            cmd,
   output gdda_pkg::dda_status_type         status,
   input  logic [gdda_pkg::DIST_BITS-1:0]   max_depth,
   input  logic                             req_command,
   input  logic [7:0]                       req_cell_index,
   input  logic [1:0]                       req_cell_value,
   input  logic [15:0]                      req_pos_x,
   input  logic [15:0]                      req_pos_y,
   input  logic signed [15:0]               req_dir_x,
   input  logic signed [15:0]               req_dir_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gdda_pkg::DIST_BITS-1:0]   rsp_perp_distance,
   output logic                             rsp_hit_side,
   output logic [1:0]                       rsp_wall_type,
   output logic [gdda_pkg::CELL_BITS-1:0]   rsp_hit_col,
   output logic [gdda_pkg::CELL_BITS-1:0]   rsp_hit_row,
   output logic [gdda_pkg::TEX_BITS-1:0]    rsp_tex_column,
   output logic                             rsp_escaped
);
   import gdda_pkg::*;

   // ray state
   logic [15:0]        px_ff, py_ff, ax_ff, ay_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic [16:0]        nx_ff, ny_ff, nlast_ff;
   logic signed [5:0]  mx_ff, my_ff;
   logic               side_ff, esc_ff;
   logic [1:0]         wt_ff;
   logic [32:0]        prodx_ff, prody_ff;
   logic signed [34:0] wpart_ff, w_ff;
   logic [DIST_BITS-1:0] dist_ff;
   logic [TEX_BITS-1:0]  tex_ff;

   // map
   logic                 valid_ff [MAP_CELLS];
   logic                 valid_rd_ff;
   logic [1:0]           ram_rdata;
   logic [ADDR_BITS-1:0] rd_addr;
   logic                 map_wr;

   // result register
   logic                 rsp_valid_ff;
   logic [DIST_BITS-1:0] out_dist_ff;
   logic                 out_side_ff;
   logic [1:0]           out_wt_ff;
   logic [CELL_BITS-1:0] out_col_ff, out_row_ff;
   logic [TEX_BITS-1:0]  out_tex_ff;
   logic                 out_esc_ff;

   logic               takex;
   logic signed [5:0]  mx_nx, my_nx;
   logic [15:0]        ax_in, ay_in;
   logic [16:0]        nx_in, ny_in;
   logic [15:0]        a_sel;
   logic [16:0]        mul_a;
   logic signed [16:0] mul_b;
   logic signed [34:0] prod;
   logic [34:0]        w_abs;
   logic [DIV_N-1:0]   div_dividend, div_quo;
   logic [DIV_D-1:0]   div_divisor;
   logic               div_busy, div_rem_nz;
   logic [TEX_BITS-1:0] q5, tex_raw;
   logic               tex_flip;

   assign map_wr = cmd.accept && (req_command == CMD_WRITE);

   assign ax_in = req_dir_x[15] ? (~$unsigned(req_dir_x) + 16'd1) : $unsigned(req_dir_x);
   assign ay_in = req_dir_y[15] ? (~$unsigned(req_dir_y) + 16'd1) : $unsigned(req_dir_y);
   // distance to the first boundary on each axis
   assign nx_in = req_dir_x[15] ? {5'd0, req_pos_x[FRAC_BITS-1:0]}
                                : 17'(CELL_ONE) - {5'd0, req_pos_x[FRAC_BITS-1:0]};
   assign ny_in = req_dir_y[15] ? {5'd0, req_pos_y[FRAC_BITS-1:0]}
                                : 17'(CELL_ONE) - {5'd0, req_pos_y[FRAC_BITS-1:0]};

   // nearer boundary by cross product, ties go to y
   assign takex = (ax_ff != 16'd0) && ((ay_ff == 16'd0) || (prodx_ff < prody_ff));
   assign mx_nx = takex ? (dx_ff[15] ? mx_ff - 6'sd1 : mx_ff + 6'sd1) : mx_ff;
   assign my_nx = takex ? my_ff : (dy_ff[15] ? my_ff - 6'sd1 : my_ff + 6'sd1);
   assign rd_addr = {my_nx[CELL_BITS-1:0], mx_nx[CELL_BITS-1:0]};

   assign a_sel = side_ff ? ay_ff : ax_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_NX_AY: begin
            mul_a = nx_ff;
            mul_b = {1'b0, ay_ff};
         end
         MUL_NY_AX: begin
            mul_a = ny_ff;
            mul_b = {1'b0, ax_ff};
         end
         MUL_P_A: begin
            mul_a = {1'b0, (side_ff ? px_ff : py_ff)};
            mul_b = {1'b0, a_sel};
         end
         default: begin
            mul_a = nlast_ff;
            mul_b = side_ff ? {dx_ff[15], dx_ff} : {dy_ff[15], dy_ff};
         end
      endcase
   end

   assign prod  = $signed({1'b0, mul_a}) * mul_b;
   assign w_abs = w_ff[34] ? $unsigned(-w_ff) : $unsigned(w_ff);

   always_comb begin
      if (cmd.div_sel == DIV_TEX) begin
         div_dividend = w_abs[DIV_N-1:0];
         div_divisor  = {a_sel, 7'd0};
      end else begin
         div_dividend = {2'd0, nlast_ff, 14'd0};
         div_divisor  = {7'd0, a_sel};
      end
   end

   gdda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo),
      .rem_nz   (div_rem_nz)
   );

   // floor quotient of a negative coordinate, low bits only
   assign q5 = div_quo[TEX_BITS-1:0];
   assign tex_raw = w_ff[34] ? (div_rem_nz ? ~q5 : ~q5 + 1'b1) : q5;
   assign tex_flip = (!side_ff && !dx_ff[15] && (dx_ff != 16'sd0)) || (side_ff && dy_ff[15]);

   gdda_ram #(
      .WIDTH (2),
      .DEPTH (MAP_CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr),
      .wr_addr (req_cell_index),
      .wr_data (req_cell_value),
      .rd_en   (cmd.step),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // valid bits give the all-zero map after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_CELLS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (map_wr) begin
         valid_ff[req_cell_index] <= 1'b1;
      end
      if (cmd.step) begin
         valid_rd_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_command == CMD_CAST)) begin
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         dx_ff   <= req_dir_x;
         dy_ff   <= req_dir_y;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         mx_ff   <= {2'd0, req_pos_x[15:FRAC_BITS]};
         my_ff   <= {2'd0, req_pos_y[15:FRAC_BITS]};
         side_ff <= 1'b0;
         esc_ff  <= 1'b0;
      end
      if (cmd.mul_x) begin
         prodx_ff <= prod[32:0];
      end
      if (cmd.mul_y) begin
         prody_ff <= prod[32:0];
      end
      if (cmd.step) begin
         mx_ff <= mx_nx;
         my_ff <= my_nx;
         if (takex) begin
            nlast_ff <= nx_ff;
            nx_ff    <= nx_ff + 17'(CELL_ONE);
            prodx_ff <= prodx_ff + {5'd0, ay_ff, 12'd0};
            side_ff  <= 1'b0;
         end else begin
            nlast_ff <= ny_ff;
            ny_ff    <= ny_ff + 17'(CELL_ONE);
            prody_ff <= prody_ff + {5'd0, ax_ff, 12'd0};
            side_ff  <= 1'b1;
         end
         if (mx_nx[5:CELL_BITS] != 2'd0 || my_nx[5:CELL_BITS] != 2'd0) begin
            esc_ff <= 1'b1;
         end
      end
      if (cmd.set_esc) begin
         esc_ff <= 1'b1;
      end
      if (cmd.latch_wt) begin
         wt_ff <= ram_rdata;
      end
      if (cmd.latch_wpart) begin
         wpart_ff <= prod;
      end
      if (cmd.latch_w) begin
         w_ff <= wpart_ff + prod;
      end
      if (cmd.latch_dist) begin
         dist_ff <= (|div_quo[DIV_N-1:DIST_BITS]) ? DIST_BITS'(DIST_MAX)
                                                  : div_quo[DIST_BITS-1:0];
      end
      if (cmd.latch_tex) begin
         tex_ff <= tex_flip ? ~tex_raw : tex_raw;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_side_ff <= side_ff;
         out_esc_ff  <= esc_ff;
         if (esc_ff) begin
            out_dist_ff <= max_depth;
            out_wt_ff   <= 2'd0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_tex_ff  <= '0;
         end else begin
            out_dist_ff <= dist_ff;
            out_wt_ff   <= wt_ff;
            out_col_ff  <= mx_ff[CELL_BITS-1:0];
            out_row_ff  <= my_ff[CELL_BITS-1:0];
            out_tex_ff  <= tex_ff;
         end
      end
   end

   assign status.zero_dir = (ax_ff == 16'd0) && (ay_ff == 16'd0);
   assign status.step_out = (mx_nx[5:CELL_BITS] != 2'd0) || (my_nx[5:CELL_BITS] != 2'd0);
   assign status.cell_hit = valid_rd_ff && (ram_rdata != 2'd0);
   assign status.div_busy = div_busy;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_perp_distance = out_dist_ff;
   assign rsp_hit_side      = out_side_ff;
   assign rsp_wall_type     = out_wt_ff;
   assign rsp_hit_col       = out_col_ff;
   assign rsp_hit_row       = out_row_ff;
   assign rsp_tex_column    = out_tex_ff;
   assign rsp_escaped       = out_esc_ff;

endmodule

// ----- sv/gdda_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdda_ctrl
// Sequencer of a cast: setup products, grid stepping with map lookups,
// distance and texture divisions, hand-off to the result register.
// ----------------------------------------------------------------------------
module gdda_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_command,
   output logic                     req_ready,
   output gdda_pkg::dda_cmd_type    cmd,
   input  gdda_pkg::dda_status_type status
);
   import gdda_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MULX   = 4'd1;
   localparam logic [3:0] S_MULY   = 4'd2;
   localparam logic [3:0] S_STEP   = 4'd3;
   localparam logic [3:0] S_TEST   = 4'd4;
   localparam logic [3:0] S_WMUL1  = 4'd5;
   localparam logic [3:0] S_WMUL2  = 4'd6;
   localparam logic [3:0] S_DSTART = 4'd7;
   localparam logic [3:0] S_DWAIT  = 4'd8;
   localparam logic [3:0] S_TSTART = 4'd9;
   localparam logic [3:0] S_TWAIT  = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && (req_command == CMD_CAST)) begin
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            cmd.mul_sel = MUL_NX_AY;
            cmd.mul_x   = 1'b1;
            state_in    = S_MULY;
         end
         S_MULY: begin
            cmd.mul_sel = MUL_NY_AX;
            cmd.mul_y   = 1'b1;
            state_in    = S_STEP;
         end
         S_STEP: begin
            if (status.zero_dir) begin
               cmd.set_esc = 1'b1;
               state_in    = S_OUT;
            end else begin
               cmd.step = 1'b1;
               state_in = status.step_out ? S_OUT : S_TEST;
            end
         end
         S_TEST: begin
            cmd.latch_wt = 1'b1;
            state_in     = status.cell_hit ? S_WMUL1 : S_STEP;
         end
         S_WMUL1: begin
            cmd.mul_sel     = MUL_P_A;
            cmd.latch_wpart = 1'b1;
            state_in        = S_WMUL2;
         end
         S_WMUL2: begin
            cmd.mul_sel = MUL_N_D;
            cmd.latch_w = 1'b1;
            state_in    = S_DSTART;
         end
         S_DSTART: begin
            cmd.div_sel   = DIV_DIST;
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            cmd.div_sel = DIV_DIST;
            if (!status.div_busy) begin
               cmd.latch_dist = 1'b1;
               state_in       = S_TSTART;
            end
         end
         S_TSTART: begin
            cmd.div_sel   = DIV_TEX;
            cmd.div_start = 1'b1;
            state_in      = S_TWAIT;
         end
         S_TWAIT: begin
            cmd.div_sel = DIV_TEX;
            if (!status.div_busy) begin
               cmd.latch_tex = 1'b1;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ----- sv/grid_ray_cast_dda_core.sv -----
// ----------------------------------------------------------------------------
// grid_ray_cast_dda_core
// 16x16 wall map with a DDA ray caster: writes store a cell, casts step the
// grid to the first wall or the map edge and report distance, side, cell
// and texture column.
//
//   channel  direction  handshake          contents
//   req_     in         req_valid/ready    command, cell write, ray start/dir
//   rsp_     out        rsp_valid/ready    one result per cast
//   csr_     in         apb psel/penable   max_depth at offset 0
//
// a write is stored when it is accepted; a cast steps the grid with one map
// read per step until it escapes at the map edge or hits a wall, and a hit
// then takes two passes of the shared bit-serial divider
// the result register lets the next item in while a result waits; a cast
// only stalls at its end if the previous result is still not taken
// reset is synchronous and clears the map to empty through per-cell valid bits
// ----------------------------------------------------------------------------
module grid_ray_cast_dda_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [7:0]                     req_cell_index,
   input  logic [1:0]                     req_cell_value,
   input  logic [15:0]                    req_pos_x,
   input  logic [15:0]                    req_pos_y,
   input  logic signed [15:0]             req_dir_x,
   input  logic signed [15:0]             req_dir_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gdda_pkg::DIST_BITS-1:0] rsp_perp_distance,
   output logic                           rsp_hit_side,
   output logic [1:0]                     rsp_wall_type,
   output logic [gdda_pkg::CELL_BITS-1:0] rsp_hit_col,
   output logic [gdda_pkg::CELL_BITS-1:0] rsp_hit_row,
   output logic [gdda_pkg::TEX_BITS-1:0]  rsp_tex_column,
   output logic                           rsp_escaped,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import gdda_pkg::*;

   logic [DIST_BITS-1:0] max_depth_ff;
   dda_cmd_type          cmd;
   dda_status_type       status;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff <= DIST_BITS'(MAX_DEPTH_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == CSR_MAX_DEPTH)) begin
         max_depth_ff <= csr_pwdata[DIST_BITS-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_MAX_DEPTH) ? {14'd0, max_depth_ff} : 32'd0;

   gdda_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .cmd         (cmd),
      .status      (status)
   );

   gdda_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .max_depth         (max_depth_ff),
      .req_command       (req_command),
      .req_cell_index    (req_cell_index),
      .req_cell_value    (req_cell_value),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_dir_x         (req_dir_x),
      .req_dir_y         (req_dir_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_perp_distance (rsp_perp_distance),
      .rsp_hit_side      (rsp_hit_side),
      .rsp_wall_type     (rsp_wall_type),
      .rsp_hit_col       (rsp_hit_col),
      .rsp_hit_row       (rsp_hit_row),
      .rsp_tex_column    (rsp_tex_column),
      .rsp_escaped       (rsp_escaped)
   );

endmodule

// ----- sv/gdda_checker.sv -----
// ----------------------------------------------------------------------------
// gdda_checker
// Port-level checks of the ray caster, bound to the top level.
// ----------------------------------------------------------------------------
module gdda_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_command,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gdda_pkg::DIST_BITS-1:0] rsp_perp_distance,
   input logic [1:0]                     rsp_wall_type,
   input logic [gdda_pkg::CELL_BITS-1:0] rsp_hit_col,
   input logic [gdda_pkg::CELL_BITS-1:0] rsp_hit_row,
   input logic [gdda_pkg::TEX_BITS-1:0]  rsp_tex_column,
   input logic                           rsp_escaped
);
   import gdda_pkg::*;

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_perp_distance)
                                  && $stable(rsp_escaped))
      else $error("result changed while stalled");

   // a cast keeps the block busy for at least the next cycle
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_CAST) |=> !req_ready)
      else $error("item taken during a cast");

   // an escape carries no cell information
   a_escape_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_escaped |-> (rsp_wall_type == 2'd0) && (rsp_hit_col == '0)
                                   && (rsp_hit_row == '0) && (rsp_tex_column == '0))
      else $error("escape with cell data");

   // a hit is always on a wall
   a_hit_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_escaped |-> rsp_wall_type != 2'd0)
      else $error("hit on an empty cell");

endmodule

bind grid_ray_cast_dda_core gdda_checker u_checker (.*);

// ----- test/ray_cast_checker.sv -----
// ----------------------------------------------------------------------------
// ray_cast_checker
// Watches the request and response channels of the grid ray caster, keeps
// its own copy of the wall map and max depth, predicts each cast result and
// compares every accepted result field by field.
// ----------------------------------------------------------------------------
module ray_cast_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_cell_index,
   input  logic [1:0]  req_cell_value,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [17:0] rsp_perp_distance,
   input  logic        rsp_hit_side,
   input  logic [1:0]  rsp_wall_type,
   input  logic [3:0]  rsp_hit_col,
   input  logic [3:0]  rsp_hit_row,
   input  logic [4:0]  rsp_tex_column,
   input  logic        rsp_escaped,
   input  logic        depth_we,
   input  logic [17:0] depth_value,
   output int          pending_casts,
   output int          fail_count
);
   import gdda_pkg::*;

   typedef struct packed {
      logic [17:0] perp;
      logic        side;
      logic [1:0]  wt;
      logic [3:0]  col;
      logic [3:0]  row;
      logic [4:0]  tex;
      logic        esc;
   } cast_result_type;

   logic [1:0]      wall_copy [MAP_CELLS];
   logic [17:0]     depth_copy;
   cast_result_type hits_due [$];

   assign pending_casts = hits_due.size();

   function automatic longint fdiv(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic cast_result_type trace_ray(logic [15:0] px16, logic [15:0] py16,
                                                 logic signed [15:0] dx16,
                                                 logic signed [15:0] dy16);
      cast_result_type r;
      longint px, py, dx, dy, ax, ay, nx, ny, nlast, a, perp_q, w, q, tex;
      int mx, my, stx, sty, side;
      bit esc, takex;
      logic [1:0] wt;
      px = px16; py = py16; dx = dx16; dy = dy16;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      mx = int'(px / CELL_ONE); my = int'(py / CELL_ONE);
      stx = dx < 0 ? -1 : 1; sty = dy < 0 ? -1 : 1;
      nx = dx < 0 ? px - mx * CELL_ONE : (mx + 1) * CELL_ONE - px;
      ny = dy < 0 ? py - my * CELL_ONE : (my + 1) * CELL_ONE - py;
      side = 0; esc = 0; wt = 0; nlast = 0;
      r = '0;
      if (ax == 0 && ay == 0) esc = 1;
      else begin
         forever begin
            if (ax == 0) takex = 0;
            else if (ay == 0) takex = 1;
            else takex = nx * ay < ny * ax;
            if (takex) begin
               nlast = nx; nx += CELL_ONE; mx += stx; side = 0;
            end else begin
               nlast = ny; ny += CELL_ONE; my += sty; side = 1;
            end
            if (mx < 0 || mx >= MAP_SIDE || my < 0 || my >= MAP_SIDE) begin
               esc = 1;
               break;
            end
            wt = wall_copy[my * MAP_SIDE + mx];
            if (wt != 0) break;
         end
      end
      r.side = 1'(side);
      if (esc) begin
         r.perp = depth_copy;
         r.esc = 1;
         return r;
      end
      a = side == 0 ? ax : ay;
      perp_q = nlast * 16384 / a;
      if (perp_q > DIST_MAX) perp_q = DIST_MAX;
      w = side == 0 ? py * ax + nlast * dy : px * ay + nlast * dx;
      q = fdiv(w * TEX_WIDTH, CELL_ONE * a);
      tex = q % TEX_WIDTH;
      if (tex < 0) tex += TEX_WIDTH;
      if ((side == 0 && dx > 0) || (side == 1 && dy < 0)) tex = TEX_WIDTH - 1 - tex;
      r.perp = 18'(perp_q); r.wt = wt; r.col = 4'(mx); r.row = 4'(my);
      r.tex = 5'(tex);
      return r;
   endfunction

   always @(posedge clock) begin
      cast_result_type got, want;
      if (reset) begin
         foreach (wall_copy[i]) wall_copy[i] = '0;
         depth_copy = 18'(MAX_DEPTH_RESET);
         hits_due.delete();
         fail_count = 0;
      end else begin
         if (depth_we) depth_copy = depth_value;
         if (rsp_valid && rsp_ready) begin
            got = {rsp_perp_distance, rsp_hit_side, rsp_wall_type, rsp_hit_col,
                   rsp_hit_row, rsp_tex_column, rsp_escaped};
            if (hits_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %h", got);
            end else begin
               want = hits_due.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch dist %0d/%0d side %0d/%0d wt %0d/%0d",
                               " col %0d/%0d row %0d/%0d tex %0d/%0d esc %0d/%0d"},
                        want.perp, got.perp, want.side, got.side, want.wt, got.wt,
                        want.col, got.col, want.row, got.row, want.tex, got.tex,
                        want.esc, got.esc);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_WRITE)
               wall_copy[req_cell_index] = req_cell_value;
            else
               hits_due.insert(hits_due.size(),
                               trace_ray(req_pos_x, req_pos_y, req_dir_x, req_dir_y));
         end
      end
   end
endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the grid ray caster: map writes and casts, directed corners
// then random maps and rays, under three idling patterns, a long response
// hold-off and several max depth settings.
// ----------------------------------------------------------------------------
module tb_top;
   import gdda_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready, req_command;
   logic [7:0] req_cell_index;
   logic [1:0] req_cell_value;
   logic [15:0] req_pos_x, req_pos_y;
   logic signed [15:0] req_dir_x, req_dir_y;
   logic rsp_valid, rsp_ready;
   logic [17:0] rsp_perp_distance;
   logic rsp_hit_side, rsp_escaped;
   logic [1:0] rsp_wall_type;
   logic [3:0] rsp_hit_col, rsp_hit_row;
   logic [4:0] rsp_tex_column;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int pending_casts, fail_count;
   int send_idle, recv_idle, hold_cycles;
   longint cycle_count;

   grid_ray_cast_dda_core DUT (.*);

   ray_cast_checker u_checker (
      .depth_we(csr_psel && csr_penable && csr_pwrite && csr_pready &&
                csr_paddr == 3'(CSR_MAX_DEPTH) * 4),
      .depth_value(csr_pwdata[17:0]), .*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 0;
         end else
            rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // valid stays up after the accepting edge until the next item or a drain
   task automatic send_item(bit cmd, logic [7:0] ci, logic [1:0] cv, logic [15:0] px,
                            logic [15:0] py, logic [15:0] dx, logic [15:0] dy);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_command <= cmd; req_cell_index <= ci; req_cell_value <= cv;
      req_pos_x <= px; req_pos_y <= py; req_dir_x <= dx; req_dir_y <= dy;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic cast(logic [15:0] px, logic [15:0] py, logic [15:0] dx, logic [15:0] dy);
      send_item(CMD_CAST, 8'($urandom), 2'($urandom), px, py, dx, dy);
   endtask

   task automatic put_wall(logic [7:0] ci, logic [1:0] cv);
      send_item(CMD_WRITE, ci, cv, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_casts != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_depth(logic [17:0] v);
      drain();
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= 3'(CSR_MAX_DEPTH) * 4;
      csr_pwdata <= {14'($urandom_range(16383)), v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_dir();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'sd16384;
         2: return -16'sd16384;
         3: return 16'($urandom);
         default: return 16'($signed($urandom_range(32768)) - 16384);
      endcase
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(2) == 0)
            put_wall(8'($urandom_range(3) == 0 ? $urandom : $urandom_range(255)),
                     2'($urandom_range(5) == 0 ? 0 : $urandom));
         else
            cast(16'($urandom), 16'($urandom), rand_dir(), rand_dir());
      end
   endtask

   initial begin
      reset = 1; req_valid = 0; req_command = 0; req_cell_index = 0; req_cell_value = 0;
      req_pos_x = 0; req_pos_y = 0; req_dir_x = 0; req_dir_y = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = 0; csr_pwdata = 0;
      send_idle = 29; recv_idle = 87; hold_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty map escapes, zero direction, ties, extremes
      cast(16'h8800, 16'h8800, 16'sd0, 16'sd0);
      cast(16'h8800, 16'h8800, 16'sd16384, 16'sd0);
      cast(16'h8800, 16'h8800, 16'sd0, -16'sd16384);
      cast(16'h0000, 16'h0000, 16'sd16384, 16'sd16384);
      cast(16'hFFFF, 16'hFFFF, -16'sd16384, -16'sd16384);
      put_wall(8'h00, 2'd3);
      put_wall(8'hFF, 2'd1);
      put_wall(8'h58, 2'd2);
      put_wall(8'h18, 2'd0);
      put_wall(8'h88, 2'd3);
      cast(16'h8800, 16'h8800, 16'sd0, 16'sd0);
      cast(16'h8800, 16'h1800, 16'sd0, -16'sd16384);
      cast(16'h2800, 16'h0800, -16'sd16384, 16'sd0);
      cast(16'hE800, 16'hE800, 16'sd1, 16'sd1);
      cast(16'h7FFF, 16'h5001, 16'sd16384, -16'sd1);
      cast(16'h4000, 16'h3000, 16'sd7000, 16'sd16384);
      cast(16'h1234, 16'h4321, 16'sh8000, 16'sd32767);
      put_wall(8'h88, 2'd0);
      set_depth(18'h3FFFF);
      cast(16'h8800, 16'h8800, 16'sd100, 16'sd3);
      set_depth(18'h0);
      cast(16'h8800, 16'h8800, -16'sd5, 16'sd0);

      random_phase(260);
      // long hold-off so the block fills up and stalls
      hold_cycles = 600;
      random_phase(20);
      drain();
      set_depth(18'($urandom));
      send_idle = 87; recv_idle = 29;
      random_phase(260);
      set_depth(18'd65536);
      send_idle = 0; recv_idle = 0;
      random_phase(260);
      drain();

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
